// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL. The clock is clk and the reset rst_n in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NMT_ASSERT_SAME(label, ante, cons)
`define NMT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/nmt_pkg.sv =====
package nmt_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LK_INT = 2'd1;
  localparam logic [1:0] FUNC_LK_EXT = 2'd2;
  localparam logic [1:0] FUNC_TICK   = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic [1:0] REG_TIMEOUT_ICMP = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_TCP  = 2'd1;
  localparam logic [1:0] REG_FIRST_PORT   = 2'd2;

  localparam logic [15:0] RST_TIMEOUT_ICMP = 16'd60;
  localparam logic [15:0] RST_TIMEOUT_TCP  = 16'd7440;
  localparam logic [15:0] RST_FIRST_PORT   = 16'd1024;

  typedef struct packed {
    logic        proto;
    logic [31:0] ip_int;
    logic [15:0] port_int;
    logic [31:0] ip_ext;
    logic [15:0] port_ext;
    logic [31:0] stamp;
    logic [31:0] order;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/nmt_if.sv =====
interface nmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] ip_int;
  logic [15:0] port_int;
  logic [31:0] ip_ext;
  logic [15:0] port_ext;
  logic        proto;
  modport source (output valid, func, ip_int, port_int, ip_ext, port_ext, proto, input ready);
  modport sink (input valid, func, ip_int, port_int, ip_ext, port_ext, proto, output ready);
endinterface

interface nmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] res_ip_int;
  logic [15:0] res_port_int;
  logic [31:0] res_ip_ext;
  logic [15:0] res_port_ext;
  logic        res_proto;
  logic [6:0]  removed;
  modport source (output valid, status, res_ip_int, res_port_int, res_ip_ext, res_port_ext,
                  res_proto, removed, input ready);
  modport sink (input valid, status, res_ip_int, res_port_int, res_ip_ext, res_port_ext,
                res_proto, removed, output ready);
endinterface

// ===== sv/nat_mapping_table.sv =====
// NAT mapping table. An insert writes the memory in its transfer cycle and its result is loaded
// into the output register from the ST_OUT state; lookups and the one-second tick scan every
// entry through the single read port of the entry memory, one entry a cycle, and then load the
// output register. One item is in work at a time and the next is taken the cycle after its
// result reaches the output register.
// Reset (synchronous, rst_n low) empties the table at once and restores registers and counters.
`include "assert_macros.svh"

module nat_mapping_table (
  input  logic        clk,
  input  logic        rst_n,
  nmt_in_if.sink      in_ch,
  nmt_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } st_t;

  localparam int IW = nmt_pkg::IDX_W;
  localparam int CW = nmt_pkg::CNT_W;

  st_t st_r, st_nxt;

  // Configuration registers.
  logic [15:0] to_icmp_r, to_tcp_r, first_port_r;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  // Running state.
  logic [nmt_pkg::ENTRIES-1:0] valid_r;
  logic [15:0] next_port_r;
  logic [31:0] now_r;
  logic [31:0] ins_cnt_r;

  // Captured request.
  logic [1:0]  op_r;
  logic [31:0] key_ip_r;
  logic [15:0] key_port_r;
  logic [15:0] key_pext_r;

  // Scan control: read address, and the index of the entry whose data arrives this cycle.
  logic [CW-1:0] scan_addr_r;
  logic          dv_r;
  logic [IW-1:0] didx_r;

  // Working result.
  logic [1:0]  res_status_r;
  logic        found_r;
  logic [31:0] best_age_r;
  nmt_pkg::entry_t res_ent_r;
  logic [6:0]  rem_cnt_r;

  // Output register.
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  nmt_pkg::entry_t out_ent_r;
  logic [6:0]  out_rem_r;

  // Memory ports.
  logic            ram_we;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  nmt_pkg::entry_t ram_wdata, ram_rdata;

  logic          in_xfer, out_xfer, out_free;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          scan_issue, scan_done;
  logic          ent_live, hit;
  logic [31:0]   age, elapsed;
  logic [15:0]   limit;

  nmt_ram #(
    .WIDTH (nmt_pkg::ENTRY_W),
    .DEPTH (nmt_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Configuration port: writes land at the access phase, reads are combinational.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    case (reg_idx)
      nmt_pkg::REG_TIMEOUT_ICMP: prdata = {16'd0, to_icmp_r};
      nmt_pkg::REG_TIMEOUT_TCP:  prdata = {16'd0, to_tcp_r};
      nmt_pkg::REG_FIRST_PORT:   prdata = {16'd0, first_port_r};
      default:                   prdata = 32'd0;
    endcase
  end

  // Lowest free slot for an insert.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = nmt_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // The insert writes the memory in its transfer cycle; scans only read, so no entry
  // is written while a read of it is in flight.
  assign ram_we    = in_xfer && (in_ch.func == nmt_pkg::FUNC_INSERT) && free_found;
  assign ram_waddr = free_idx;
  always_comb begin
    ram_wdata          = '0;
    ram_wdata.proto    = in_ch.proto;
    ram_wdata.ip_int   = in_ch.ip_int;
    ram_wdata.port_int = in_ch.port_int;
    ram_wdata.ip_ext   = in_ch.ip_ext;
    ram_wdata.port_ext = next_port_r;
    ram_wdata.stamp    = now_r;
    ram_wdata.order    = ins_cnt_r;
  end

  assign scan_issue = (st_r == ST_SCAN) && (scan_addr_r != CW'(nmt_pkg::ENTRIES));
  assign scan_done  = (st_r == ST_SCAN) && (scan_addr_r == CW'(nmt_pkg::ENTRIES)) && !dv_r;
  assign ram_raddr  = scan_addr_r[IW-1:0];

  // Evaluation of the entry that arrives from memory.
  assign ent_live = dv_r && valid_r[didx_r];
  assign age      = ins_cnt_r - ram_rdata.order;
  assign elapsed  = now_r - ram_rdata.stamp;
  assign limit    = ram_rdata.proto ? to_tcp_r : to_icmp_r;
  assign hit      = (op_r == nmt_pkg::FUNC_LK_INT) ?
                    (ram_rdata.ip_int == key_ip_r && ram_rdata.port_int == key_port_r) :
                    (ram_rdata.port_ext == key_pext_r);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_xfer) begin
          st_nxt = (in_ch.func == nmt_pkg::FUNC_INSERT) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      to_icmp_r    <= nmt_pkg::RST_TIMEOUT_ICMP;
      to_tcp_r     <= nmt_pkg::RST_TIMEOUT_TCP;
      first_port_r <= nmt_pkg::RST_FIRST_PORT;
      valid_r      <= '0;
      next_port_r  <= nmt_pkg::RST_FIRST_PORT;
      now_r        <= '0;
      ins_cnt_r    <= '0;
      scan_addr_r  <= '0;
      dv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr) begin
        case (reg_idx)
          nmt_pkg::REG_TIMEOUT_ICMP: to_icmp_r    <= pwdata[15:0];
          nmt_pkg::REG_TIMEOUT_TCP:  to_tcp_r     <= pwdata[15:0];
          nmt_pkg::REG_FIRST_PORT:   first_port_r <= pwdata[15:0];
          default: ;
        endcase
      end
      if (ram_we) begin
        valid_r[free_idx] <= 1'b1;
        ins_cnt_r         <= ins_cnt_r + 32'd1;
        next_port_r       <= (next_port_r == 16'hFFFF) ? first_port_r : next_port_r + 16'd1;
      end
      if (in_xfer && in_ch.func == nmt_pkg::FUNC_TICK) begin
        now_r <= now_r + 32'd1;
      end
      if (in_xfer) begin
        scan_addr_r <= '0;
      end else if (scan_issue) begin
        scan_addr_r <= scan_addr_r + CW'(1);
      end
      dv_r <= scan_issue;
      // Expiry takes the entry out at once; it is the only entry touched this cycle.
      if (ent_live && op_r == nmt_pkg::FUNC_TICK && elapsed >= {16'd0, limit}) begin
        valid_r[didx_r] <= 1'b0;
      end
      if (st_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    didx_r <= ram_raddr;
    if (in_xfer) begin
      op_r       <= in_ch.func;
      key_ip_r   <= in_ch.ip_int;
      key_port_r <= in_ch.port_int;
      key_pext_r <= in_ch.port_ext;
      found_r    <= 1'b0;
      best_age_r <= '0;
      rem_cnt_r  <= '0;
      if (in_ch.func == nmt_pkg::FUNC_INSERT) begin
        if (free_found) begin
          res_status_r <= nmt_pkg::STATUS_OK;
          res_ent_r    <= ram_wdata;
        end else begin
          res_status_r <= nmt_pkg::STATUS_FULL;
          res_ent_r    <= '0;
        end
      end else if (in_ch.func == nmt_pkg::FUNC_TICK) begin
        res_status_r <= nmt_pkg::STATUS_OK;
        res_ent_r    <= '0;
      end else begin
        res_status_r <= nmt_pkg::STATUS_NOT_FOUND;
        res_ent_r    <= '0;
      end
    end else if (ent_live) begin
      if (op_r == nmt_pkg::FUNC_TICK) begin
        if (elapsed >= {16'd0, limit}) begin
          rem_cnt_r <= rem_cnt_r + 7'd1;
        end
      end else if (hit && (!found_r || age > best_age_r)) begin
        // Strictly older replaces, so a tie stays with the lower slot.
        found_r      <= 1'b1;
        best_age_r   <= age;
        res_ent_r    <= ram_rdata;
        res_status_r <= nmt_pkg::STATUS_OK;
      end
    end
    if (st_r == ST_OUT && out_free) begin
      out_status_r <= res_status_r;
      out_ent_r    <= res_ent_r;
      out_rem_r    <= rem_cnt_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.res_ip_int   = out_ent_r.ip_int;
  assign out_ch.res_port_int = out_ent_r.port_int;
  assign out_ch.res_ip_ext   = out_ent_r.ip_ext;
  assign out_ch.res_port_ext = out_ent_r.port_ext;
  assign out_ch.res_proto    = out_ent_r.proto;
  assign out_ch.removed      = out_rem_r;

  `NMT_ASSERT_NEXT(a_accept_leaves_idle, in_xfer, st_r != ST_IDLE)
  `NMT_ASSERT_NEXT(a_result_loaded, st_r == ST_OUT && out_free, out_valid_r)
  `NMT_ASSERT_SAME(a_scan_only_in_scan, dv_r, st_r == ST_SCAN)

endmodule

// ===== sv/nmt_ram.sv =====
module nmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
